// ===== src/ipv4_header_check_and_forward_defines.svh =====
// assertion macros for the module that checks itself
`ifndef IPV4_HEADER_CHECK_AND_FORWARD_DEFINES_SVH
`define IPV4_HEADER_CHECK_AND_FORWARD_DEFINES_SVH

// same-cycle implication, masked during reset
`define IHCF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define IHCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ihcf_pkg.sv =====
package ihcf_pkg;

    localparam int LOCAL_ADDRESS_COUNT_DEF = 4;
    localparam int MAX_LOCAL_ADDRESSES     = 4;
    localparam int MID_QUEUE_DEPTH         = 2;
    localparam int OUT_QUEUE_DEPTH         = 2;

    localparam int WORD_W      = 16;
    localparam int ADDR_W      = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int WORD_IDX_W  = 5;
    localparam int VERDICT_W   = 3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_ENABLE = 3'd4;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_LOCAL        = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_FORWARD      = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_BAD_CHECKSUM = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_BAD_VERSION  = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_BAD_LENGTH   = 3'd4;
    localparam logic [VERDICT_W-1:0] VERDICT_TTL_ZERO     = 3'd5;
    localparam logic [VERDICT_W-1:0] VERDICT_TTL_EXPIRED  = 3'd6;

    // header word positions
    localparam logic [WORD_IDX_W-1:0] WORD_VER_IHL   = 5'd0;
    localparam logic [WORD_IDX_W-1:0] WORD_TTL_PROTO = 5'd4;
    localparam logic [WORD_IDX_W-1:0] WORD_CHECKSUM  = 5'd5;
    localparam logic [WORD_IDX_W-1:0] WORD_SRC_HI    = 5'd6;
    localparam logic [WORD_IDX_W-1:0] WORD_SRC_LO    = 5'd7;
    localparam logic [WORD_IDX_W-1:0] WORD_DST_HI    = 5'd8;
    localparam logic [WORD_IDX_W-1:0] WORD_DST_LO    = 5'd9;
    localparam logic [WORD_IDX_W-1:0] MIN_LAST_WORD  = 5'd9;

    localparam logic [3:0]        IP_VERSION_4  = 4'd4;
    localparam logic [3:0]        IHL_MIN       = 4'd5;
    localparam logic [7:0]        TTL_ZERO      = 8'd0;
    localparam logic [7:0]        TTL_ONE       = 8'd1;
    localparam logic [WORD_W-1:0] TTL_DEC_ADDEND = 16'hfeff;

    typedef struct packed {
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] check;
        logic [3:0]        version;
        logic [3:0]        ihl;
        logic [7:0]        ttl;
        logic [7:0]        proto;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
    } t_hdr_rec;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [ADDR_W-1:0]    dst;
        logic [ADDR_W-1:0]    src;
        logic [7:0]           proto;
        logic [3:0]           ihl;
        logic [7:0]           ttl;
        logic [WORD_W-1:0]    checksum;
    } t_result;

    // one's-complement add with end-around carry
    function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

// ===== src/ihcf_fifo.sv =====
module ihcf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/ihcf_front.sv =====
module ihcf_front
    import ihcf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [WORD_W-1:0] i_header_word,
    input  logic              i_first_word,
    output logic              o_rec_valid,
    output t_hdr_rec          o_rec,
    output logic              o_busy
);

    logic                  r_active, n_active;
    logic [WORD_IDX_W-1:0] r_word_count, n_word_count;
    logic [WORD_W-1:0]     r_sum, n_sum;
    logic [WORD_W-1:0]     r_check, n_check;
    logic [3:0]            r_version, n_version;
    logic [3:0]            r_ihl, n_ihl;
    logic [7:0]            r_ttl, n_ttl;
    logic [7:0]            r_proto, n_proto;
    logic [ADDR_W-1:0]     r_src, n_src;
    logic [ADDR_W-1:0]     r_dst, n_dst;

    logic [WORD_IDX_W-1:0] idx, last, span;
    logic [WORD_W-1:0]     base_sum;

    always_comb begin
        n_active     = r_active;
        n_word_count = r_word_count;
        n_sum        = r_sum;
        n_check      = r_check;
        n_version    = r_version;
        n_ihl        = r_ihl;
        n_ttl        = r_ttl;
        n_proto      = r_proto;
        n_src        = r_src;
        n_dst        = r_dst;
        o_rec_valid  = 1'b0;
        idx          = i_first_word ? '0 : r_word_count;
        base_sum     = i_first_word ? '0 : r_sum;
        span         = '0;
        last         = '0;
        if (i_valid && (i_first_word || r_active)) begin
            case (idx)
                WORD_VER_IHL: begin
                    n_version = i_header_word[15:12];
                    n_ihl     = i_header_word[11:8];
                end
                WORD_TTL_PROTO: begin
                    n_ttl   = i_header_word[15:8];
                    n_proto = i_header_word[7:0];
                end
                WORD_CHECKSUM: n_check         = i_header_word;
                WORD_SRC_HI:   n_src[31:16]    = i_header_word;
                WORD_SRC_LO:   n_src[15:0]     = i_header_word;
                WORD_DST_HI:   n_dst[31:16]    = i_header_word;
                WORD_DST_LO:   n_dst[15:0]     = i_header_word;
                default: ;
            endcase
            span  = {n_ihl, 1'b0};
            n_sum = base_sum;
            if (idx < span && idx != WORD_CHECKSUM) begin
                n_sum = oc_add(base_sum, i_header_word);
            end
            last = (n_ihl < IHL_MIN) ? MIN_LAST_WORD : span - 1'b1;
            if (idx < last) begin
                n_word_count = idx + 1'b1;
                n_active     = 1'b1;
            end else begin
                n_word_count = '0;
                n_active     = 1'b0;
                o_rec_valid  = 1'b1;
            end
        end
    end

    always_comb begin
        o_rec.sum     = n_sum;
        o_rec.check   = n_check;
        o_rec.version = n_version;
        o_rec.ihl     = n_ihl;
        o_rec.ttl     = n_ttl;
        o_rec.proto   = n_proto;
        o_rec.src     = n_src;
        o_rec.dst     = n_dst;
    end

    assign o_busy = r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_word_count <= '0;
        end else begin
            r_active     <= n_active;
            r_word_count <= n_word_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum     <= n_sum;
        r_check   <= n_check;
        r_version <= n_version;
        r_ihl     <= n_ihl;
        r_ttl     <= n_ttl;
        r_proto   <= n_proto;
        r_src     <= n_src;
        r_dst     <= n_dst;
    end

endmodule

// ===== src/ihcf_back.sv =====
module ihcf_back
    import ihcf_pkg::*;
#(
    parameter int LOCAL_ADDRESS_COUNT = LOCAL_ADDRESS_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]      i_cfg_data,
    input  logic                   i_rec_valid,
    input  t_hdr_rec               i_rec,
    input  logic                   i_out_ready,
    output logic                   o_take,
    output t_result                o_result
);

    logic [ADDR_W-1:0]              r_local_addr [LOCAL_ADDRESS_COUNT];
    logic [LOCAL_ADDRESS_COUNT-1:0] r_local_enable;
    logic                           is_local;
    logic [WORD_W-1:0]              fwd_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LOCAL_ADDRESS_COUNT; i++) begin
                r_local_addr[i] <= '0;
            end
            r_local_enable <= '0;
        end else if (i_cfg_we) begin
            for (int i = 0; i < LOCAL_ADDRESS_COUNT; i++) begin
                if (i_cfg_index == CFG_INDEX_W'(i)) begin
                    r_local_addr[i] <= i_cfg_data;
                end
            end
            if (i_cfg_index == REG_LOCAL_ENABLE) begin
                r_local_enable <= i_cfg_data[LOCAL_ADDRESS_COUNT-1:0];
            end
        end
    end

    always_comb begin
        is_local = 1'b0;
        for (int i = 0; i < LOCAL_ADDRESS_COUNT; i++) begin
            if (r_local_enable[i] && r_local_addr[i] == i_rec.dst) begin
                is_local = 1'b1;
            end
        end
    end

    // lowering ttl by one takes 0x0100 off the sum
    assign fwd_sum = oc_add(i_rec.sum, TTL_DEC_ADDEND);
    assign o_take  = i_rec_valid && i_out_ready;

    always_comb begin
        o_result.dst      = i_rec.dst;
        o_result.src      = i_rec.src;
        o_result.proto    = i_rec.proto;
        o_result.ihl      = i_rec.ihl;
        o_result.ttl      = i_rec.ttl;
        o_result.checksum = i_rec.check;
        if (i_rec.check != ~i_rec.sum) begin
            o_result.verdict = VERDICT_BAD_CHECKSUM;
        end else if (i_rec.version != IP_VERSION_4) begin
            o_result.verdict = VERDICT_BAD_VERSION;
        end else if (i_rec.ihl < IHL_MIN) begin
            o_result.verdict = VERDICT_BAD_LENGTH;
        end else if (i_rec.ttl == TTL_ZERO) begin
            o_result.verdict = VERDICT_TTL_ZERO;
        end else if (is_local) begin
            o_result.verdict = VERDICT_LOCAL;
        end else if (i_rec.ttl == TTL_ONE) begin
            o_result.verdict = VERDICT_TTL_EXPIRED;
        end else begin
            o_result.verdict  = VERDICT_FORWARD;
            o_result.ttl      = i_rec.ttl - 1'b1;
            o_result.checksum = ~fwd_sum;
        end
    end

endmodule

// ===== src/ipv4_header_check_and_forward.sv =====
// the last word of a header puts its record in the middle queue; throughput: one
// header word per cycle while that queue is not full; a header is 10 to 30 words,
// one result each; the front adds one word per cycle and the back classifies one
// header per cycle, each while its queue has room; reset (synchronous, active low)
// empties both queues, clears the local addresses and enables, and leaves the
// parser idle until an item with first_word set
`include "ipv4_header_check_and_forward_defines.svh"

module ipv4_header_check_and_forward
    import ihcf_pkg::*;
#(
    parameter int LOCAL_ADDRESS_COUNT = LOCAL_ADDRESS_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // header word input side
    input  logic                   push,
    output logic                   full,
    input  logic [WORD_W-1:0]      i_header_word,
    input  logic                   i_first_word,
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]      i_cfg_data,
    // result queue side
    output logic                   empty,
    input  logic                   pop,
    output logic [VERDICT_W-1:0]   o_verdict,
    output logic [ADDR_W-1:0]      o_dest_address,
    output logic [ADDR_W-1:0]      o_source_address,
    output logic [7:0]             o_proto_number,
    output logic [3:0]             o_header_length_words,
    output logic [7:0]             o_new_ttl,
    output logic [WORD_W-1:0]      o_new_checksum
);

    localparam int REC_W = $bits(t_hdr_rec);
    localparam int RES_W = $bits(t_result);

    // front side: word accepted and finished header record
    logic     in_take;
    logic     front_rec_valid;
    logic     front_busy;
    t_hdr_rec front_rec;

    // queue between front and back
    logic [REC_W-1:0] mid_rdata;
    logic             mid_full, mid_empty;
    t_hdr_rec         mid_head;

    // back side: verdict and result queue
    logic             back_take;
    t_result          back_result;
    logic [RES_W-1:0] out_rdata;
    logic             out_full;
    t_result          out_head;

    // only the last word of a header produces a record, but a full queue
    // stalls every word so the record always has a slot
    assign full    = mid_full;
    assign in_take = push && !mid_full;

    ihcf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_take),
        .i_header_word (i_header_word),
        .i_first_word  (i_first_word),
        .o_rec_valid   (front_rec_valid),
        .o_rec         (front_rec),
        .o_busy        (front_busy)
    );

    // short queue lets the parser keep going while the result side stalls
    ihcf_fifo #(
        .WIDTH (REC_W),
        .DEPTH (MID_QUEUE_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_rec_valid),
        .i_data  (front_rec),
        .i_pop   (back_take),
        .o_data  (mid_rdata),
        .o_full  (mid_full),
        .o_empty (mid_empty)
    );

    assign mid_head = t_hdr_rec'(mid_rdata);

    // verdict logic, local address compare and checksum update
    ihcf_back #(
        .LOCAL_ADDRESS_COUNT (LOCAL_ADDRESS_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rec_valid (!mid_empty),
        .i_rec       (mid_head),
        .i_out_ready (!out_full),
        .o_take      (back_take),
        .o_result    (back_result)
    );

    // result queue: the oldest item sits on the output ports
    ihcf_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_take),
        .i_data  (back_result),
        .i_pop   (pop),
        .o_data  (out_rdata),
        .o_full  (out_full),
        .o_empty (empty)
    );

    assign out_head              = t_result'(out_rdata);
    assign o_verdict             = out_head.verdict;
    assign o_dest_address        = out_head.dst;
    assign o_source_address      = out_head.src;
    assign o_proto_number        = out_head.proto;
    assign o_header_length_words = out_head.ihl;
    assign o_new_ttl             = out_head.ttl;
    assign o_new_checksum        = out_head.checksum;

    // a finished header leaves the parser idle
    `IHCF_ASSERT_NEXT(a_front_idle_after_rec, i_clk, i_rst_n, front_rec_valid,
        !front_busy, "parser still busy after handing off a header")

    // a forwarded item never carries a zero ttl
    `IHCF_ASSERT_NOW(a_forward_ttl_nonzero, i_clk, i_rst_n,
        !empty && o_verdict == VERDICT_FORWARD, o_new_ttl != TTL_ZERO,
        "forward verdict with zero ttl")

    // only a header of legal length is delivered or forwarded
    `IHCF_ASSERT_NOW(a_valid_has_length, i_clk, i_rst_n,
        !empty && (o_verdict == VERDICT_LOCAL || o_verdict == VERDICT_FORWARD),
        o_header_length_words >= IHL_MIN, "accepted header with short ihl")

endmodule
